/* hw/rtl/ect_pkg.sv */
// Shared types and constants for the exponential covariance pipeline.
package ect_pkg;

    localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [16:0] INV_LN2_Q16  = 17'd94548;      // floor(2^48 / LN2_Q32)
    localparam logic [31:0] EXP_CUT_Q16  = 32'd1507328;    // 23.0 in Q16.16
    localparam int          TAYLOR_TERMS = 12;
    localparam int          X_W          = 21;             // x below the cutoff
    localparam int          K_W          = 6;              // k is at most 33
    localparam int          IDX_W        = 10;             // row and column index width
    localparam int          DATA_W       = 56;             // request payload, byte padded

    typedef struct packed {
        logic            frc;   // result is forced, no exponential
        logic            one;   // forced value is 1.0, else 0
        logic [K_W-1:0]  k;
        logic [31:0]     r;
        logic [32:0]     sum;
        logic [31:0]     term;
    } t_ctx;

endpackage

/* hw/rtl/exponential_covariance_triangle.sv */
// Exponential covariance kernel over the lower triangle, one entry per cycle.
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Cost is set by four front stages, eleven 3-stage Taylor term units and one output stage.
// Reset clears all stage valid bits and loads decay_rate with 1.0 (65536).
module exponential_covariance_triangle #(
    parameter int MAX_N = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [31:0]                i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ect_pkg::DATA_W-1:0] s_axis_tdata,   // row_index, col_index, distance, zero pad
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata    // covariance
);
    import ect_pkg::*;

    localparam int NSTEP  = TAYLOR_TERMS - 1;

    logic              w_en;
    logic [IDX_W-1:0]  w_row, w_col;
    logic [31:0]       w_dist;
    logic              w_oor, w_diag, w_above;

    logic [31:0]       r_rate;

    logic              r_v1, r_v2, r_v3, r_v4, r_out_vld;
    logic [63:0]       r_prod;
    logic              r_frc1, r_one1, r_frc2, r_one2, r_frc3, r_one3;
    logic [X_W-1:0]    r_x2, r_x3;
    logic [37:0]       r_km;
    logic [37:0]       r_kl;
    logic [K_W-1:0]    r_k3;
    t_ctx              r_c4;
    logic [31:0]       r_out_data;

    logic [31:0]       w_x;
    logic [37:0]       w_r0;
    logic              w_corr;
    logic [31:0]       w_r;
    logic [34:0]       w_rnd;
    logic [34:0]       w_shf;
    t_ctx              w_fin;

    t_ctx              w_ctx [0:NSTEP];
    logic [NSTEP:0]    w_vld;

    assign w_row  = s_axis_tdata[IDX_W-1:0];
    assign w_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_dist = s_axis_tdata[2*IDX_W+31:2*IDX_W];

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 32'd65536;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_oor   = (32'(w_row) >= 32'(MAX_N)) || (32'(w_col) >= 32'(MAX_N));
        w_diag  = w_row == w_col;
        w_above = w_col > w_row;
        w_x     = (|r_prod[63:48]) ? 32'hFFFF_FFFF : r_prod[47:16];
        w_r0    = {1'b0, r_x3, 16'h0000} - r_kl;
        w_corr  = w_r0 >= 38'(LN2_Q32);
        w_r     = w_corr ? 32'(w_r0 - 38'(LN2_Q32)) : w_r0[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_out_vld <= w_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 64'(w_dist) * 64'(r_rate);
            r_frc1 <= w_oor || w_diag || w_above;
            r_one1 <= !w_oor && w_diag;

            r_frc2 <= r_frc1 || (w_x >= EXP_CUT_Q16);
            r_one2 <= r_one1;
            r_x2   <= w_x[X_W-1:0];
            r_km   <= 38'(w_x[X_W-1:0]) * 38'(INV_LN2_Q16);

            r_frc3 <= r_frc2;
            r_one3 <= r_one2;
            r_x3   <= r_x2;
            r_k3   <= r_km[37:32];
            r_kl   <= 38'(r_km[37:32]) * 38'(LN2_Q32);

            r_c4.frc  <= r_frc3;
            r_c4.one  <= r_one3;
            r_c4.k    <= r_k3 + K_W'(w_corr);
            r_c4.r    <= w_r;
            r_c4.sum  <= ONE_Q32 - {1'b0, w_r};
            r_c4.term <= w_r;

            r_out_data <= w_fin.frc ? (w_fin.one ? ONE_Q31 : 32'd0) : w_shf[31:0];
        end
    end

    assign w_ctx[0] = r_c4;
    assign w_vld[0] = r_v4;

    for (genvar g = 0; g < NSTEP; g++) begin : g_term
        ect_taylor_step #(
            .DIVISOR(g + 2)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_ctx   (w_ctx[g]),
            .o_vld   (w_vld[g+1]),
            .o_ctx   (w_ctx[g+1])
        );
    end

    // round to Q1.31 and scale by 2^-k
    always_comb begin
        w_fin = w_ctx[NSTEP];
        w_rnd = {2'b00, w_fin.sum} + (35'd1 << w_fin.k);
        w_shf = w_rnd >> (w_fin.k + K_W'(1));
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_cov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_data <= ONE_Q31))
        else $error("covariance above 1.0");

    a_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_c4.frc) |-> ((r_c4.k <= K_W'(33)) && (r_c4.r < LN2_Q32)))
        else $error("range reduction out of bounds");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted request lost at first stage");

endmodule

/* hw/rtl/ect_taylor_step.sv */
// One Taylor term of exp(-r): term = ((term * r) >> 32) / DIVISOR, then accumulate.
module ect_taylor_step #(
    parameter int DIVISOR = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  ect_pkg::t_ctx i_ctx,
    output logic         o_vld,
    output ect_pkg::t_ctx o_ctx
);
    import ect_pkg::*;

    localparam logic [31:0] RECIP  = 32'(64'h1_0000_0000 / DIVISOR);
    localparam logic [31:0] DIV_C  = 32'(DIVISOR);
    localparam bit          IS_ADD = (DIVISOR % 2) == 0;

    logic        r_v1, r_v2, r_v3;
    t_ctx        r_c1, r_c2, r_c3;
    logic [63:0] r_p;
    logic [63:0] r_e;
    logic [31:0] r_q;

    logic [31:0] w_est;
    logic [31:0] w_rem;
    logic [31:0] w_term;
    t_ctx        n_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= 64'(i_ctx.term) * 64'(i_ctx.r);
            r_c1 <= i_ctx;
            r_q  <= r_p[63:32];
            r_e  <= 64'(r_p[63:32]) * 64'(RECIP);
            r_c2 <= r_c1;
            r_c3 <= n_c3;
        end
    end

    // reciprocal estimate is low by at most one
    always_comb begin
        w_est  = r_e[63:32];
        w_rem  = r_q - 32'(w_est * DIV_C);
        w_term = (w_rem >= DIV_C) ? w_est + 32'd1 : w_est;
        n_c3      = r_c2;
        n_c3.term = w_term;
        if (IS_ADD) begin
            n_c3.sum = r_c2.sum + {1'b0, w_term};
        end else begin
            n_c3.sum = r_c2.sum - {1'b0, w_term};
        end
    end

    assign o_vld = r_v3;
    assign o_ctx = r_c3;

endmodule
